// ===== hdl/lcdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD timing package
// Shared codes, register addresses, limits and record types of the LCD mode
// timing and register block.
// ----------------------------------------------------------------------------
package lcdt_pkg;

	// Line geometry of one frame.
	localparam int unsigned VISIBLE_LINES = 144;
	localparam int unsigned BLANK_LINES   = 10;
	localparam logic [7:0]  LINE_VBLANK   = 8'(VISIBLE_LINES);
	localparam logic [7:0]  LINE_WRAP     = 8'(VISIBLE_LINES + BLANK_LINES);

	// Widths.
	localparam int unsigned TIME_W  = 10;
	localparam int unsigned CYCLE_W = 16;
	localparam int unsigned NUM_CFG = 4;
	localparam int unsigned CFG_IDX_W = $clog2(NUM_CFG);

	// Timing register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] CFG_OAM_TIME      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_TIME = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HBLANK_TIME   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_TIME     = 2'd3;

	localparam logic [TIME_W-1:0] OAM_TIME_RST      = 10'd80;
	localparam logic [TIME_W-1:0] TRANSFER_TIME_RST = 10'd172;
	localparam logic [TIME_W-1:0] HBLANK_TIME_RST   = 10'd204;
	localparam logic [TIME_W-1:0] LINE_TIME_RST     = 10'd456;

	// Display modes.
	localparam logic [1:0] MODE_HBLANK = 2'd0;
	localparam logic [1:0] MODE_VBLANK = 2'd1;
	localparam logic [1:0] MODE_OAM    = 2'd2;
	localparam logic [1:0] MODE_XFER   = 2'd3;

	// Request commands.
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	// Register map.
	localparam logic [7:0] ADDR_CONTROL = 8'h40;
	localparam logic [7:0] ADDR_STATUS  = 8'h41;
	localparam logic [7:0] ADDR_SCY     = 8'h42;
	localparam logic [7:0] ADDR_SCX     = 8'h43;
	localparam logic [7:0] ADDR_LY      = 8'h44;
	localparam logic [7:0] ADDR_LYC     = 8'h45;
	localparam logic [7:0] ADDR_BGP     = 8'h47;
	localparam logic [7:0] ADDR_OBP0    = 8'h48;
	localparam logic [7:0] ADDR_OBP1    = 8'h49;

	// Status byte fields.
	localparam logic [7:0] STATUS_WR_MASK = 8'b0111_1000;
	localparam int unsigned STAT_COINCIDENCE = 2;
	localparam int unsigned STAT_IE_HBLANK   = 3;
	localparam int unsigned STAT_IE_VBLANK   = 4;
	localparam int unsigned STAT_IE_OAM      = 5;
	localparam int unsigned STAT_IE_LYC      = 6;

	typedef struct packed {
		logic [TIME_W-1:0] oam_time;
		logic [TIME_W-1:0] transfer_time;
		logic [TIME_W-1:0] hblank_time;
		logic [TIME_W-1:0] line_time;
	} timing_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [CYCLE_W-1:0] cycles;
		logic [7:0]         line;
		logic [7:0]         control;
		logic [7:0]         status;
		logic [7:0]         scy;
		logic [7:0]         scx;
		logic [7:0]         lyc;
		logic [7:0]         bgp;
		logic [7:0]         obp0;
		logic [7:0]         obp1;
	} lcd_state_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       lcd_irq;
		logic       vblank_irq;
		logic       frame_done;
		logic [1:0] mode;
		logic [7:0] row;
	} result_t;

endpackage

// ===== hdl/lcdt_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD timing engine
// Next-state and result logic for one request: a tick step of the mode
// sequencer, or a register read or write.
// ----------------------------------------------------------------------------
module lcdt_engine (
	input  lcdt_pkg::lcd_state_t cur,
	input  lcdt_pkg::timing_t    timing,
	input  logic [1:0]           command,
	input  logic [7:0]           address,
	input  logic [7:0]           write_data,
	input  logic [7:0]           elapsed,
	output lcdt_pkg::lcd_state_t nxt,
	output lcdt_pkg::result_t    res
);
	import lcdt_pkg::*;

	logic [CYCLE_W:0]   sum;
	logic [CYCLE_W-1:0] sat;
	logic [TIME_W-1:0]  dur;
	logic               step;
	logic [CYCLE_W-1:0] left;
	logic [7:0]         line_inc;
	logic [7:0]         tick_line;
	logic [1:0]         tick_mode;
	logic               tick_irq;
	logic               tick_vb;
	logic               coinc;
	logic [7:0]         rdata;
	logic [7:0]         status_rd;

	// Saturating cycle counter and the duration of the current mode.
	always_comb begin
		sum = {1'b0, cur.cycles} + {{(CYCLE_W - 7){1'b0}}, elapsed};
		sat = sum[CYCLE_W] ? {CYCLE_W{1'b1}} : sum[CYCLE_W-1:0];
		unique case (cur.mode)
			MODE_OAM:    dur = timing.oam_time;
			MODE_XFER:   dur = timing.transfer_time;
			MODE_HBLANK: dur = timing.hblank_time;
			default:     dur = timing.line_time;
		endcase
		step     = sat >= {{(CYCLE_W - TIME_W){1'b0}}, dur};
		left     = sat - {{(CYCLE_W - TIME_W){1'b0}}, dur};
		line_inc = cur.line + 8'd1;
	end

	// Mode sequencer step.
	always_comb begin
		tick_mode = cur.mode;
		tick_line = cur.line;
		tick_irq  = 1'b0;
		tick_vb   = 1'b0;
		if (step) begin
			unique case (cur.mode)
				MODE_OAM: begin
					tick_mode = MODE_XFER;
				end
				MODE_XFER: begin
					tick_mode = MODE_HBLANK;
					tick_irq  = cur.status[STAT_IE_HBLANK];
				end
				MODE_HBLANK: begin
					tick_line = line_inc;
					if (line_inc == LINE_VBLANK) begin
						tick_mode = MODE_VBLANK;
						tick_irq  = cur.status[STAT_IE_VBLANK];
						tick_vb   = 1'b1;
					end else begin
						tick_mode = MODE_OAM;
						tick_irq  = cur.status[STAT_IE_OAM];
					end
				end
				default: begin
					tick_line = line_inc;
					if (line_inc >= LINE_WRAP) begin
						tick_mode = MODE_OAM;
						tick_irq  = cur.status[STAT_IE_OAM];
						tick_line = 8'd0;
					end
				end
			endcase
		end
		coinc = tick_line == cur.lyc;
	end

	// Register read data; a status read folds the mode into the stored byte.
	always_comb begin
		status_rd = {cur.status[7:2], cur.mode};
		unique case (address)
			ADDR_CONTROL: rdata = cur.control;
			ADDR_STATUS:  rdata = status_rd;
			ADDR_SCY:     rdata = cur.scy;
			ADDR_SCX:     rdata = cur.scx;
			ADDR_LY:      rdata = cur.line;
			ADDR_LYC:     rdata = cur.lyc;
			ADDR_BGP:     rdata = cur.bgp;
			ADDR_OBP0:    rdata = cur.obp0;
			ADDR_OBP1:    rdata = cur.obp1;
			default:      rdata = 8'd0;
		endcase
	end

	always_comb begin
		nxt = cur;
		res = '0;
		case (command)
			CMD_TICK: begin
				nxt.cycles = step ? left : sat;
				nxt.mode   = tick_mode;
				nxt.line   = tick_line;
				nxt.status[STAT_COINCIDENCE] = coinc;
				res.lcd_irq    = tick_irq | (cur.status[STAT_IE_LYC] & coinc);
				res.vblank_irq = tick_vb;
				res.frame_done = tick_vb;
			end
			CMD_READ: begin
				res.read_data = rdata;
				if (address == ADDR_STATUS) begin
					nxt.status = status_rd;
				end
			end
			CMD_WRITE: begin
				unique case (address)
					ADDR_CONTROL: nxt.control = write_data;
					ADDR_STATUS:  nxt.status  = (cur.status & ~STATUS_WR_MASK) |
					                            (write_data & STATUS_WR_MASK);
					ADDR_SCY:     nxt.scy  = write_data;
					ADDR_SCX:     nxt.scx  = write_data;
					ADDR_LYC:     nxt.lyc  = write_data;
					ADDR_BGP:     nxt.bgp  = write_data;
					ADDR_OBP0:    nxt.obp0 = write_data;
					ADDR_OBP1:    nxt.obp1 = write_data;
					default:      nxt = cur;
				endcase
			end
			default: begin
				nxt = cur;
			end
		endcase
		res.mode = nxt.mode;
		res.row  = nxt.line;
	end

endmodule

// ===== hdl/lcd_mode_timing_registers.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode timing and register block
// Display mode sequencer (OAM search, transfer, HBlank, VBlank) with the
// status interrupt logic and the LCD register byte file.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the item channel (item_valid / item_stall) with a
// command, an address, write data and an elapsed cycle count. A tick request
// advances the cycle counter and makes at most one mode step; a read or
// write request reaches the register bytes at 0x40 to 0x49. Every request
// yields exactly one result on the result channel (result_valid /
// result_stall) carrying read data, interrupt flags, the mode and the row.
// A result is registered in the main or the skid register. Throughput is one
// request per clock while item_stall is low; the state update for a request
// is a single add, compare and subtract in the engine.
// The result side has a main register and a one-entry skid register, so a
// new request is still taken while a finished result waits. Only when both
// are full does item_stall rise, and it stays high until the receiver takes
// a result. Results leave in request order.
// The user must write the timing registers (cfg_write / cfg_index / cfg_data)
// only while the block is idle, which it does not enforce. Reset zeroes all
// mode and register state, loads timing defaults and empties the result slots.
// ----------------------------------------------------------------------------
module lcd_mode_timing_registers (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [1:0]                      command,
	input  logic [7:0]                      address,
	input  logic [7:0]                      write_data,
	input  logic [7:0]                      elapsed,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [7:0]                      read_data,
	output logic                            lcd_irq,
	output logic                            vblank_irq,
	output logic                            frame_done,
	output logic [1:0]                      current_mode,
	output logic [7:0]                      current_row,
	input  logic                            cfg_write,
	input  logic [lcdt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lcdt_pkg::TIME_W-1:0]     cfg_data
);
	import lcdt_pkg::*;

	timing_t    timing_q;
	lcd_state_t state_q;
	lcd_state_t state_nxt;
	result_t    res_nxt;
	result_t    main_q;
	result_t    skid_q;
	logic       main_valid_q;
	logic       skid_valid_q;
	logic       accept;
	logic       take;

	// The skid register absorbs one result while the receiver stalls, so the
	// request side only stalls when both result slots are occupied.
	assign item_stall = skid_valid_q;
	assign accept     = item_valid & ~skid_valid_q;
	assign take       = main_valid_q & ~result_stall;

	lcdt_engine u_engine (
		.cur        (state_q),
		.timing     (timing_q),
		.command    (command),
		.address    (address),
		.write_data (write_data),
		.elapsed    (elapsed),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// Timing registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.oam_time      <= OAM_TIME_RST;
			timing_q.transfer_time <= TRANSFER_TIME_RST;
			timing_q.hblank_time   <= HBLANK_TIME_RST;
			timing_q.line_time     <= LINE_TIME_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_OAM_TIME:      timing_q.oam_time      <= cfg_data;
				CFG_TRANSFER_TIME: timing_q.transfer_time <= cfg_data;
				CFG_HBLANK_TIME:   timing_q.hblank_time   <= cfg_data;
				default:           timing_q.line_time     <= cfg_data;
			endcase
		end
	end

	// Mode and register state advance once per accepted request. The all-zero
	// reset value puts the sequencer in HBlank on line zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// Result slots: valid bits under reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (!main_valid_q || take) begin
					main_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (take) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					main_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!main_valid_q || take) begin
				main_q <= res_nxt;
			end else begin
				skid_q <= res_nxt;
			end
		end else if (take && skid_valid_q) begin
			main_q <= skid_q;
		end
	end

	assign result_valid = main_valid_q;
	assign read_data    = main_q.read_data;
	assign lcd_irq      = main_q.lcd_irq;
	assign vblank_irq   = main_q.vblank_irq;
	assign frame_done   = main_q.frame_done;
	assign current_mode = main_q.mode;
	assign current_row  = main_q.row;

	// The skid slot is only ever filled behind a waiting main result.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid slot holds a result while the main slot is empty");

	// VBlank is only entered at the first blank line and left before the wrap.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.mode == MODE_VBLANK) |-> (state_q.line >= LINE_VBLANK) &&
		(state_q.line < LINE_WRAP))
		else $error("vblank mode outside the blank lines");

	// A frame-done result always reports VBlank on the first blank line.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && frame_done) |-> vblank_irq &&
		(current_mode == MODE_VBLANK) && (current_row == LINE_VBLANK))
		else $error("frame done without vblank entry");

	// A register access never steps the mode sequencer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (command != CMD_TICK)) |=> $stable(state_q.mode) &&
		$stable(state_q.line) && $stable(state_q.cycles))
		else $error("register access changed the mode timing state");

endmodule
